// ----- design/sedd_pkg.sv -----
// sedd_pkg: shared types, constants and helpers of the serpentine error-diffusion dither
// used by the core, the checker and the testbench
`default_nettype none
package sedd_pkg;

  localparam int unsigned LINE_MAX_DEF     = 4096;
  localparam int unsigned PALETTE_SIZE_DEF = 16;

  localparam int unsigned ERR_W = 12;
  localparam int unsigned TAG_W = 8;
  localparam int unsigned AMT_W = 11;
  localparam int unsigned CFG_W = 13;
  localparam int unsigned CFG_IDX_W = 2;

  // floor(p / 100) = (p * RECIP) >> RECIP_SHIFT for every p below 91180
  localparam logic [16:0] RECIP       = 17'd83887;
  localparam int unsigned RECIP_SHIFT = 23;

  localparam logic [1:0] OP_PIXEL = 2'd0;
  localparam logic [1:0] OP_ROW   = 2'd1;
  localparam logic [1:0] OP_PAL   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_FACTOR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TRANSP = 2'd3;

  typedef enum logic [3:0] {
    ST_CLR,
    ST_IDLE,
    ST_RD,
    ST_LD,
    ST_SRCH,
    ST_MUL,
    ST_DIV,
    ST_SPL,
    ST_URD,
    ST_UWR,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic [TAG_W-1:0]        tag;
    logic signed [ERR_W-1:0] alp;
    logic signed [ERR_W-1:0] lum;
  } cell_t;

  localparam int unsigned CELL_W = $bits(cell_t);

  // saturating error accumulate
  function automatic logic signed [ERR_W-1:0] err_add(input logic signed [ERR_W-1:0] c,
                                                      input logic signed [AMT_W-1:0] a);
    logic signed [ERR_W:0] s;
    s = {c[ERR_W-1], c} + {{(ERR_W+1-AMT_W){a[AMT_W-1]}}, a};
    if (s < -13'sd2048) begin
      return -12'sd2048;
    end else if (s > 13'sd2047) begin
      return 12'sd2047;
    end
    return s[ERR_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ----- design/sedd_if.sv -----
// sedd_in_if and sedd_out_if: valid/ready channels of the dither core
// depends on nothing
`default_nettype none
interface sedd_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [11:0] column;
  logic        odd_row;
  logic [7:0]  lum_in;
  logic [7:0]  alpha_in;
  logic [3:0]  entry_slot;

  modport source (output valid, op, column, odd_row, lum_in, alpha_in, entry_slot,
                  input ready);
  modport sink (input valid, op, column, odd_row, lum_in, alpha_in, entry_slot,
                output ready);
endinterface

interface sedd_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] color_index;

  modport source (output valid, color_index, input ready);
  modport sink (input valid, color_index, output ready);
endinterface
`default_nettype wire

// ----- design/sedd_ram.sv -----
// sedd_ram: one error line bank, one write and one read port, registered read data
// depends on nothing
`default_nettype none
module sedd_ram #(
  parameter int unsigned DEPTH = 4098,
  parameter int unsigned WIDTH = 32
) (
  input  wire                      clk_i,
  input  wire                      we_i,
  input  wire [$clog2(DEPTH)-1:0]  waddr_i,
  input  wire [WIDTH-1:0]          wdata_i,
  input  wire [$clog2(DEPTH)-1:0]  raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

// ----- design/serpentine_error_diffusion_dither_core.sv -----
// Serpentine two-channel error-diffusion dither core. A pixel beat is read, loaded,
// searched over palette_count entries (count taken as 1..PALETTE_SIZE), multiplied,
// divided, split into three next-row error updates and offered until out_ch.ready; the
// search visits one entry a cycle, each update needs a read and a write-back on one bank
// port. Palette loads, unused ops, pixels beyond the line width and row starts other
// than at a tag wrap are taken without leaving the idle state. The error rows live in
// two swapped banks of LINE_MAX+2 words with a row tag each; after reset both banks,
// and when a bank's tag wraps (at two adjacent row starts in every 512) the retired
// bank, are swept to zero while no beat is accepted (configuration writes still are).
// depends on sedd_pkg, sedd_if, sedd_ram
`default_nettype none
module serpentine_error_diffusion_dither_core #(
  parameter int unsigned LINE_MAX     = sedd_pkg::LINE_MAX_DEF,
  parameter int unsigned PALETTE_SIZE = sedd_pkg::PALETTE_SIZE_DEF
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  sedd_in_if.sink                          in_ch,
  sedd_out_if.source                       out_ch,
  input  wire                              cfg_we_i,
  input  wire [sedd_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire [sedd_pkg::CFG_W-1:0]        cfg_data_i
);
  import sedd_pkg::*;

  localparam int unsigned DEPTH = LINE_MAX + 2;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned PIW   = (PALETTE_SIZE > 1) ? $clog2(PALETTE_SIZE) : 1;

  state_e state_q, state_d;

  logic [7:0]  factor_q;
  logic [12:0] width_q;
  logic [4:0]  count_q;
  logic [4:0]  transp_q;

  logic [7:0] pal_lum_q [PALETTE_SIZE];
  logic [7:0] pal_alp_q [PALETTE_SIZE];

  logic             sel_q;
  logic [TAG_W-1:0] epoch_q [2];
  logic [1:0]       clr_mask_q;
  logic [AW-1:0]    clr_addr_q;

  logic [11:0] col_q;
  logic        odd_q;
  logic [7:0]  lum_q, alp_q;
  logic [7:0]  vl_q, va_q;
  logic [PIW-1:0] idx_q, best_q;
  logic [17:0] best_d_q;
  logic [7:0]  best_l_q, best_a_q;
  logic        sl_q, sa_q;
  logic [15:0] pl_q, pa_q;
  logic [9:0]  ql_q, qa_q;
  logic signed [AMT_W-1:0] lamt_q [4];
  logic signed [AMT_W-1:0] aamt_q [4];
  logic [1:0]  k_q;
  logic        out_valid_q;
  logic [3:0]  out_idx_q;

  logic            mem_we    [2];
  logic [AW-1:0]   mem_waddr [2];
  logic [CELL_W-1:0] mem_wdata [2];
  logic [AW-1:0]   mem_raddr [2];
  logic [CELL_W-1:0] mem_rdata [2];

  for (genvar b = 0; b < 2; b++) begin : g_bank
    sedd_ram #(.DEPTH(DEPTH), .WIDTH(CELL_W)) u_ram (
      .clk_i   (clk_i),
      .we_i    (mem_we[b]),
      .waddr_i (mem_waddr[b]),
      .wdata_i (mem_wdata[b]),
      .raddr_i (mem_raddr[b]),
      .rdata_o (mem_rdata[b])
    );
  end

  // effective limits
  logic [31:0] w_eff, n_eff;
  always_comb begin
    w_eff = 32'(width_q);
    if (w_eff == 32'd0) w_eff = 32'd1;
    if (w_eff > LINE_MAX) w_eff = LINE_MAX;
    n_eff = 32'(count_q);
    if (n_eff == 32'd0) n_eff = 32'd1;
    if (n_eff > PALETTE_SIZE) n_eff = PALETTE_SIZE;
  end

  logic in_acc, pix_ok, wrap, clr_last, srch_last, out_load;
  logic [TAG_W-1:0] epoch_inc;
  assign in_acc    = in_ch.valid && in_ch.ready;
  assign pix_ok    = (in_ch.op == OP_PIXEL) && (32'(in_ch.column) < w_eff);
  assign epoch_inc = epoch_q[sel_q] + 1'b1;
  assign wrap      = (epoch_inc == '0);
  assign clr_last  = (32'(clr_addr_q) == DEPTH - 1);
  assign srch_last = (32'(idx_q) + 32'd1 >= n_eff);
  assign out_load  = (state_q == ST_OUT) && (!out_valid_q || out_ch.ready);

  // addresses of the current pixel
  logic [31:0] a_ctr, a_nxt, a_cur;
  logic [AW-1:0] addr_ctr, addr_nxt, addr_cur;
  assign a_ctr    = 32'(col_q) + 32'd1;
  assign a_nxt    = 32'(col_q) + 32'(k_q);
  assign a_cur    = odd_q ? 32'(col_q) : 32'(col_q) + 32'd2;
  assign addr_ctr = a_ctr[AW-1:0];
  assign addr_nxt = a_nxt[AW-1:0];
  assign addr_cur = a_cur[AW-1:0];

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLR:  if (clr_last) state_d = ST_IDLE;
      ST_IDLE: begin
        if (in_acc) begin
          if (pix_ok) begin
            state_d = ST_RD;
          end else if (in_ch.op == OP_ROW && wrap) begin
            state_d = ST_CLR;
          end
        end
      end
      ST_RD:   state_d = ST_LD;
      ST_LD:   state_d = ST_SRCH;
      ST_SRCH: if (srch_last) state_d = ST_MUL;
      ST_MUL:  state_d = ST_DIV;
      ST_DIV:  state_d = ST_SPL;
      ST_SPL:  state_d = ST_URD;
      ST_URD:  state_d = ST_UWR;
      ST_UWR:  state_d = (k_q == 2'd2) ? ST_OUT : ST_URD;
      ST_OUT:  if (out_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // bank amount picked for the next-row word k, mirrored on odd rows
  logic [1:0] sel_amt;
  always_comb begin
    unique case (k_q)
      2'd0:    sel_amt = odd_q ? 2'd3 : 2'd1;
      2'd1:    sel_amt = 2'd2;
      default: sel_amt = odd_q ? 2'd1 : 2'd3;
    endcase
  end

  cell_t rd_cur, rd_nxt, wr_cur, wr_nxt;
  logic  cur_b, nxt_b;
  assign cur_b  = sel_q;
  assign nxt_b  = !sel_q;
  assign rd_cur = cell_t'(mem_rdata[cur_b]);
  assign rd_nxt = cell_t'(mem_rdata[nxt_b]);

  // stale tags read as zero
  logic signed [ERR_W-1:0] cur_l, cur_a, nxt_l, nxt_a;
  always_comb begin
    cur_l = (rd_cur.tag == epoch_q[cur_b]) ? rd_cur.lum : '0;
    cur_a = (rd_cur.tag == epoch_q[cur_b]) ? rd_cur.alp : '0;
    nxt_l = (rd_nxt.tag == epoch_q[nxt_b]) ? rd_nxt.lum : '0;
    nxt_a = (rd_nxt.tag == epoch_q[nxt_b]) ? rd_nxt.alp : '0;
    wr_cur.tag = epoch_q[cur_b];
    wr_cur.lum = err_add(cur_l, lamt_q[0]);
    wr_cur.alp = err_add(cur_a, aamt_q[0]);
    wr_nxt.tag = epoch_q[nxt_b];
    wr_nxt.lum = err_add(nxt_l, lamt_q[sel_amt]);
    wr_nxt.alp = err_add(nxt_a, aamt_q[sel_amt]);
  end

  // memory controls and handshake
  always_comb begin
    for (int b = 0; b < 2; b++) begin
      mem_we[b]    = 1'b0;
      mem_waddr[b] = clr_addr_q;
      mem_wdata[b] = '0;
      mem_raddr[b] = addr_ctr;
    end
    unique case (state_q)
      ST_CLR: begin
        for (int b = 0; b < 2; b++) mem_we[b] = clr_mask_q[b];
      end
      ST_URD: begin
        mem_raddr[nxt_b] = addr_nxt;
        mem_raddr[cur_b] = addr_cur;
      end
      ST_UWR: begin
        mem_we[nxt_b]    = 1'b1;
        mem_waddr[nxt_b] = addr_nxt;
        mem_wdata[nxt_b] = wr_nxt;
        mem_we[cur_b]    = (k_q == 2'd0);
        mem_waddr[cur_b] = addr_cur;
        mem_wdata[cur_b] = wr_cur;
      end
      default: ;
    endcase
  end

  assign in_ch.ready        = (state_q == ST_IDLE);
  assign out_ch.valid       = out_valid_q;
  assign out_ch.color_index = out_idx_q;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      factor_q    <= 8'd100;
      width_q     <= 13'd4096;
      count_q     <= 5'd16;
      transp_q    <= 5'd16;
      sel_q       <= 1'b0;
      epoch_q[0]  <= '0;
      epoch_q[1]  <= '0;
      clr_mask_q  <= 2'b11;
      clr_addr_q  <= '0;
      out_valid_q <= 1'b0;
      k_q         <= '0;
      idx_q       <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_FACTOR: factor_q <= cfg_data_i[7:0];
          CFG_WIDTH:  width_q  <= cfg_data_i;
          CFG_COUNT:  count_q  <= cfg_data_i[4:0];
          CFG_TRANSP: transp_q <= cfg_data_i[4:0];
          default: ;
        endcase
      end
      if (state_q == ST_CLR) begin
        clr_addr_q <= clr_last ? '0 : clr_addr_q + 1'b1;
      end
      if (state_q == ST_IDLE && in_acc && in_ch.op == OP_ROW) begin
        sel_q          <= !sel_q;
        epoch_q[sel_q] <= epoch_inc;
        clr_mask_q     <= sel_q ? 2'b10 : 2'b01;
      end
      if (state_q == ST_LD) idx_q <= '0;
      if (state_q == ST_SRCH) idx_q <= idx_q + 1'b1;
      if (state_q == ST_SPL) k_q <= '0;
      if (state_q == ST_UWR) k_q <= k_q + 1'b1;
      if (out_ch.ready) out_valid_q <= 1'b0;
      if (out_load) out_valid_q <= 1'b1;
    end
  end

  // palette store, loaded by beat
  logic [31:0] slot_ext;
  assign slot_ext = 32'(in_ch.entry_slot);
  always_ff @(posedge clk_i) begin
    if (in_acc && in_ch.op == OP_PAL && slot_ext < PALETTE_SIZE) begin
      pal_lum_q[slot_ext[PIW-1:0]] <= in_ch.lum_in;
      pal_alp_q[slot_ext[PIW-1:0]] <= in_ch.alpha_in;
    end
  end

  // datapath
  logic signed [13:0] sum_l, sum_a;
  logic signed [8:0]  dl, da;
  logic [17:0]        sq_dist;
  logic               transp;
  logic [7:0]         pl_e, pa_e;
  logic signed [8:0]  el, ea;
  logic [32:0]        prod_l, prod_a;
  logic [12:0]        m7l, m3l, m5l, m7a, m3a, m5a;
  logic [31:0]        best_ext;

  always_comb begin
    sum_l = $signed({6'b0, lum_q}) + 14'(cur_l);
    sum_a = $signed({6'b0, alp_q}) + 14'(cur_a);
    dl    = $signed({1'b0, vl_q}) - $signed({1'b0, pal_lum_q[idx_q]});
    da    = $signed({1'b0, va_q}) - $signed({1'b0, pal_alp_q[idx_q]});
    sq_dist = 18'(dl * dl) + 18'(da * da);
    best_ext = 32'(best_q);
    transp = (best_ext == 32'(transp_q)) || (best_a_q == 8'd0);
    pl_e  = transp ? lum_q : best_l_q;
    pa_e  = transp ? 8'd0 : best_a_q;
    el    = $signed({1'b0, vl_q}) - $signed({1'b0, pl_e});
    ea    = $signed({1'b0, va_q}) - $signed({1'b0, pa_e});
    prod_l = 33'(pl_q) * 33'(RECIP);
    prod_a = 33'(pa_q) * 33'(RECIP);
    m7l = 13'(ql_q) * 13'd7;
    m3l = 13'(ql_q) * 13'd3;
    m5l = 13'(ql_q) * 13'd5;
    m7a = 13'(qa_q) * 13'd7;
    m3a = 13'(qa_q) * 13'd3;
    m5a = 13'(qa_q) * 13'd5;
  end

  function automatic logic signed [AMT_W-1:0] sgn(input logic neg, input logic [12:0] m);
    logic signed [AMT_W-1:0] v;
    v = $signed(m[AMT_W-1:0]);
    return neg ? -v : v;
  endfunction

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      col_q <= in_ch.column;
      odd_q <= in_ch.odd_row;
      lum_q <= in_ch.lum_in;
      alp_q <= in_ch.alpha_in;
    end
    if (state_q == ST_LD) begin
      vl_q <= (sum_l < 0) ? 8'd0 : (sum_l > 14'sd255) ? 8'd255 : sum_l[7:0];
      va_q <= (sum_a < 0) ? 8'd0 : (sum_a > 14'sd255) ? 8'd255 : sum_a[7:0];
    end
    if (state_q == ST_SRCH && (idx_q == '0 || sq_dist < best_d_q)) begin
      best_q   <= idx_q;
      best_d_q <= sq_dist;
      best_l_q <= pal_lum_q[idx_q];
      best_a_q <= pal_alp_q[idx_q];
    end
    if (state_q == ST_MUL) begin
      sl_q <= el[8];
      sa_q <= ea[8];
      pl_q <= 16'(el[8] ? -el : el) * 16'(factor_q);
      pa_q <= 16'(ea[8] ? -ea : ea) * 16'(factor_q);
    end
    if (state_q == ST_DIV) begin
      ql_q <= prod_l[RECIP_SHIFT+9:RECIP_SHIFT];
      qa_q <= prod_a[RECIP_SHIFT+9:RECIP_SHIFT];
    end
    if (state_q == ST_SPL) begin
      lamt_q[0] <= sgn(sl_q, m7l >> 4);
      lamt_q[1] <= sgn(sl_q, m3l >> 4);
      lamt_q[2] <= sgn(sl_q, m5l >> 4);
      lamt_q[3] <= sgn(sl_q, 13'(ql_q) >> 4);
      aamt_q[0] <= sgn(sa_q, m7a >> 4);
      aamt_q[1] <= sgn(sa_q, m3a >> 4);
      aamt_q[2] <= sgn(sa_q, m5a >> 4);
      aamt_q[3] <= sgn(sa_q, 13'(qa_q) >> 4);
    end
    if (out_load) out_idx_q <= best_ext[3:0];
  end
endmodule
`default_nettype wire

// ----- design/sedd_checker.sv -----
// sedd_checker: port-level checks of the dither core, bound into the core module
// depends on sedd_pkg and the core
`default_nettype none
module sedd_checker (
  input wire       clk_i,
  input wire       rst_ni,
  input wire       in_valid,
  input wire       in_ready,
  input wire [1:0] in_op,
  input wire       out_valid,
  input wire       out_ready,
  input wire [3:0] color_index
);
  import sedd_pkg::*;

  // the input is not ready as reset is released, since the error rows are swept first
  a_sweep_after_reset: assert property (@(posedge clk_i) $rose(rst_ni) |-> !in_ready)
    else $error("beat taken during reset sweep");

  // a palette load never stalls the input
  a_pal_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready && in_op == OP_PAL |=> in_ready)
    else $error("palette load stalled input");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> $stable(color_index))
    else $error("result beat changed while stalled");
endmodule

bind serpentine_error_diffusion_dither_core sedd_checker u_sedd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .in_op       (in_ch.op),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .color_index (out_ch.color_index)
);
`default_nettype wire

// ----- bench/serpentine_error_diffusion_dither_core_tb.sv -----
// testbench of serpentine_error_diffusion_dither_core: directed and random beats under
// several register settings and idling patterns, checked against an in-bench predictor
// depends on sedd_pkg, sedd_if and the core
`default_nettype none
module serpentine_error_diffusion_dither_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sedd_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int ERR_DEPTH = LINE_MAX_DEF + 2;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int SETTLE_CYCLES = 48;

  typedef struct packed {
    logic [1:0]  op;
    logic [11:0] column;
    logic        odd_row;
    logic [7:0]  lum;
    logic [7:0]  alpha;
    logic [3:0]  slot;
  } beat_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0] cfg_data;

  sedd_in_if  in_if ();
  sedd_out_if out_if ();

  serpentine_error_diffusion_dither_core DUT (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data)
  );

  // predictor state
  int lum_cur [ERR_DEPTH];
  int lum_nxt [ERR_DEPTH];
  int alp_cur [ERR_DEPTH];
  int alp_nxt [ERR_DEPTH];
  logic [7:0] pal_lum [16];
  logic [7:0] pal_alp [16];
  logic [7:0]  factor_reg;
  logic [12:0] width_reg;
  logic [4:0]  count_reg;
  logic [4:0]  transp_reg;

  beat_t pending_beats [$];
  logic [3:0] expected_index [$];
  beat_t driven_beat;
  int send_idle_pct;
  int recv_stall_pct;
  int mismatches;
  int beats_taken;
  int pixels_checked;
  int cycles;

  function automatic int sat_err(input int v);
    if (v < -2048) return -2048;
    if (v > 2047) return 2047;
    return v;
  endfunction

  function automatic int clamp_px(input int v);
    if (v < 0) return 0;
    if (v > 255) return 255;
    return v;
  endfunction

  function automatic void diffuse(input bit alpha_ch, input int x, input int e, input bit odd);
    int q, a, b, c, d;
    q = e * int'(factor_reg) / 100;
    a = q * 7 / 16;
    b = q * 3 / 16;
    c = q * 5 / 16;
    d = q / 16;
    if (!alpha_ch) begin
      if (odd) begin
        lum_cur[x]   = sat_err(lum_cur[x] + a);
        lum_nxt[x+2] = sat_err(lum_nxt[x+2] + b);
        lum_nxt[x+1] = sat_err(lum_nxt[x+1] + c);
        lum_nxt[x]   = sat_err(lum_nxt[x] + d);
      end else begin
        lum_cur[x+2] = sat_err(lum_cur[x+2] + a);
        lum_nxt[x]   = sat_err(lum_nxt[x] + b);
        lum_nxt[x+1] = sat_err(lum_nxt[x+1] + c);
        lum_nxt[x+2] = sat_err(lum_nxt[x+2] + d);
      end
    end else begin
      if (odd) begin
        alp_cur[x]   = sat_err(alp_cur[x] + a);
        alp_nxt[x+2] = sat_err(alp_nxt[x+2] + b);
        alp_nxt[x+1] = sat_err(alp_nxt[x+1] + c);
        alp_nxt[x]   = sat_err(alp_nxt[x] + d);
      end else begin
        alp_cur[x+2] = sat_err(alp_cur[x+2] + a);
        alp_nxt[x]   = sat_err(alp_nxt[x] + b);
        alp_nxt[x+1] = sat_err(alp_nxt[x+1] + c);
        alp_nxt[x+2] = sat_err(alp_nxt[x+2] + d);
      end
    end
  endfunction

  function automatic int eff_width();
    if (width_reg == 0) return 1;
    if (width_reg > LINE_MAX_DEF) return LINE_MAX_DEF;
    return int'(width_reg);
  endfunction

  // advance the predictor by one accepted beat
  function automatic void dither_beat(input beat_t b);
    int w, n, vl, va, best, best_d, dl, da, sq_dist, pl, pa, x;
    if (b.op == OP_ROW) begin
      for (int i = 0; i < ERR_DEPTH; i++) begin
        lum_cur[i] = lum_nxt[i];
        alp_cur[i] = alp_nxt[i];
        lum_nxt[i] = 0;
        alp_nxt[i] = 0;
      end
    end else if (b.op == OP_PAL) begin
      pal_lum[b.slot] = b.lum;
      pal_alp[b.slot] = b.alpha;
    end else if (b.op == OP_PIXEL) begin
      w = eff_width();
      x = int'(b.column);
      if (x < w) begin
        vl = clamp_px(int'(b.lum) + lum_cur[x+1]);
        va = clamp_px(int'(b.alpha) + alp_cur[x+1]);
        n = (count_reg == 0) ? 1 : (count_reg > 16) ? 16 : int'(count_reg);
        best = 0;
        best_d = 0;
        for (int i = 0; i < n; i++) begin
          dl = vl - int'(pal_lum[i]);
          da = va - int'(pal_alp[i]);
          sq_dist = dl * dl + da * da;
          if (i == 0 || sq_dist < best_d) begin
            best = i;
            best_d = sq_dist;
          end
        end
        pl = int'(pal_lum[best]);
        pa = int'(pal_alp[best]);
        if (best == int'(transp_reg) || pa == 0) begin
          pl = int'(b.lum);
          pa = 0;
        end
        diffuse(1'b0, x, vl - pl, b.odd_row);
        diffuse(1'b1, x, va - pa, b.odd_row);
        expected_index.push_back(best[3:0]);
      end
    end
  endfunction

  initial begin
    clk_i = 1'b0;
  end
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        dither_beat(driven_beat);
        beats_taken++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (pending_beats.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          driven_beat = pending_beats.pop_front();
          in_if.op         <= driven_beat.op;
          in_if.column     <= driven_beat.column;
          in_if.odd_row    <= driven_beat.odd_row;
          in_if.lum_in     <= driven_beat.lum;
          in_if.alpha_in   <= driven_beat.alpha;
          in_if.entry_slot <= driven_beat.slot;
          in_if.valid      <= 1'b1;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_index.size() == 0) begin
          $error("color_index beat with nothing expected: actual %0d", out_if.color_index);
          mismatches++;
        end else begin
          if (out_if.color_index !== expected_index[0]) begin
            $error("color_index mismatch: expected %0d actual %0d",
                   expected_index[0], out_if.color_index);
            mismatches++;
          end
          void'(expected_index.pop_front());
          pixels_checked++;
        end
      end
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats left", cycles, pending_beats.size());
      $display("serpentine_error_diffusion_dither_core regression: fail");
      $finish;
    end
  end

  function automatic beat_t mk(input logic [1:0] op, input int col, input bit odd,
                               input int lum, input int alpha, input int slot);
    beat_t b;
    b.op = op;
    b.column = col[11:0];
    b.odd_row = odd;
    b.lum = lum[7:0];
    b.alpha = alpha[7:0];
    b.slot = slot[3:0];
    return b;
  endfunction

  function automatic beat_t rand_pixel(input int col, input bit odd);
    return mk(OP_PIXEL, col, odd, $urandom_range(255), $urandom_range(255), $urandom_range(15));
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val[CFG_W-1:0];
    @(posedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      CFG_FACTOR: factor_reg = val[7:0];
      CFG_WIDTH:  width_reg  = val[12:0];
      CFG_COUNT:  count_reg  = val[4:0];
      default:    transp_reg = val[4:0];
    endcase
  endtask

  task automatic settle();
    while (pending_beats.size() > 0 || in_if.valid || expected_index.size() > 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // a well-formed serpentine row, wide rows cut to a short run
  task automatic queue_row(input bit odd, inout int added);
    int w, len, start, col;
    w = eff_width();
    pending_beats.push_back(mk(OP_ROW, $urandom_range(4095), $urandom_range(1), 0, 0, 0));
    added++;
    len = (w > 12) ? $urandom_range(12, 1) : w;
    start = (w > 12) ? $urandom_range(w - 1) : (odd ? w - 1 : 0);
    for (int i = 0; i < len; i++) begin
      col = odd ? start - i : start + i;
      if (col < 0 || col >= w) break;
      pending_beats.push_back(rand_pixel(col, odd));
      added++;
    end
  endtask

  task automatic queue_random(input int target);
    int added, r, col, w;
    bit odd;
    added = 0;
    odd = 1'b0;
    while (added < target) begin
      r = $urandom_range(99);
      w = eff_width();
      if (r < 68) begin
        queue_row(odd, added);
        odd = ~odd;
      end else if (r < 78) begin
        // same column over and over to drive the error into saturation
        col = $urandom_range(w - 1);
        repeat ($urandom_range(8, 3)) begin
          pending_beats.push_back(mk(OP_PIXEL, col, odd, $urandom_range(1) * 255,
                                     $urandom_range(1) * 255, 0));
          added++;
        end
      end else if (r < 88) begin
        pending_beats.push_back(mk(OP_PAL, $urandom_range(4095), $urandom_range(1),
                                   $urandom_range(255),
                                   ($urandom_range(4) == 0) ? 0 : $urandom_range(255),
                                   $urandom_range(15)));
        added++;
      end else if (r < 94) begin
        pending_beats.push_back(rand_pixel($urandom_range(4095), $urandom_range(1)));
        added++;
      end else begin
        pending_beats.push_back(mk(OP_UNUSED, $urandom_range(4095), $urandom_range(1),
                                   $urandom_range(255), $urandom_range(255),
                                   $urandom_range(15)));
        added++;
      end
    end
  endtask

  int settings [8][4] = '{
    '{100, 8, 16, 16}, '{0, 1, 1, 0}, '{200, 5, 16, 3}, '{255, 0, 0, 31},
    '{150, 4096, 16, 16}, '{37, 8191, 7, 5}, '{100, 13, 31, 15}, '{200, 3, 2, 1}
  };

  initial begin
    in_if.valid = 1'b0;
    in_if.op = OP_UNUSED;
    in_if.column = '0;
    in_if.odd_row = 1'b0;
    in_if.lum_in = '0;
    in_if.alpha_in = '0;
    in_if.entry_slot = '0;
    out_if.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    mismatches = 0;
    beats_taken = 0;
    pixels_checked = 0;
    cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    for (int i = 0; i < ERR_DEPTH; i++) begin
      lum_cur[i] = 0;
      lum_nxt[i] = 0;
      alp_cur[i] = 0;
      alp_nxt[i] = 0;
    end
    for (int i = 0; i < 16; i++) begin
      pal_lum[i] = '0;
      pal_alp[i] = '0;
    end
    factor_reg = 8'd100;
    width_reg = 13'd4096;
    count_reg = 5'd16;
    transp_reg = 5'd16;

    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: whole palette first so no unloaded entry is ever searched
    for (int i = 0; i < 16; i++)
      pending_beats.push_back(mk(OP_PAL, 0, 0, i * 17, (i % 5 == 2) ? 0 : 255 - i * 16, i));
    pending_beats.push_back(mk(OP_PAL, 4095, 1, 255, 255, 15));
    pending_beats.push_back(mk(OP_ROW, 0, 0, 0, 0, 0));
    pending_beats.push_back(mk(OP_PIXEL, 0, 0, 0, 0, 0));
    pending_beats.push_back(mk(OP_PIXEL, 1, 0, 255, 255, 0));
    pending_beats.push_back(mk(OP_PIXEL, 4095, 0, 128, 0, 0));
    pending_beats.push_back(mk(OP_UNUSED, 4095, 1, 255, 255, 15));
    pending_beats.push_back(mk(OP_ROW, 4095, 1, 255, 255, 15));
    pending_beats.push_back(mk(OP_PIXEL, 4095, 1, 255, 0, 15));
    pending_beats.push_back(mk(OP_PIXEL, 4094, 1, 0, 255, 0));
    settle();

    for (int p = 0; p < 8; p++) begin
      for (int k = 0; k < 4; k++)
        write_reg(k[CFG_IDX_W-1:0], settings[p][k]);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
        default: begin send_idle_pct = 22; recv_stall_pct = 22; end
      endcase
      queue_random(150);
      settle();
    end

    $display("%0d beats accepted over 8 register settings and 4 idling patterns", beats_taken);
    $display("%0d colour indices checked, %0d mismatches", pixels_checked, mismatches);
    if (mismatches == 0) begin
      $display("serpentine_error_diffusion_dither_core regression: pass");
    end else begin
      $display("serpentine_error_diffusion_dither_core regression: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ----- files.f -----
design/sedd_pkg.sv
design/sedd_if.sv
design/sedd_ram.sv
design/serpentine_error_diffusion_dither_core.sv
design/sedd_checker.sv
bench/serpentine_error_diffusion_dither_core_tb.sv
